>>> hdl/bgre_pkg.sv
package bgre_pkg;

  // Defaults for the top-level parameters.
  localparam int FONT_BYTES_DEF = 16384;
  localparam int MAX_WIDTH_DEF  = 32;

  // Glyph geometry limits.
  localparam int          MAX_ROWS   = 32;
  localparam logic [7:0]  FIRST_CODE = 8'd32;

  // Command codes of an input item.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_BASE   = 2'd2,
    REG_INK    = 2'd3
  } cfg_reg_t;

  // Register reset values.
  localparam logic [5:0]  RST_WIDTH  = 6'd17;
  localparam logic [5:0]  RST_HEIGHT = 6'd24;
  localparam logic [13:0] RST_BASE   = 14'd0;
  localparam logic [15:0] RST_INK    = 16'hFFFF;

endpackage

>>> hdl/bgre_if.sv
interface bgre_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [13:0] load_address;
  logic [7:0]  load_byte;
  logic [7:0]  char_code;
  logic [15:0] origin_x;
  logic [15:0] origin_y;

  modport source (output valid, command, load_address, load_byte, char_code,
                  origin_x, origin_y, input ready);
  modport sink   (input valid, command, load_address, load_byte, char_code,
                  origin_x, origin_y, output ready);
endinterface

interface bgre_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] row_x;
  logic [15:0] row_y;
  logic [31:0] row_bits;
  logic [15:0] color;
  logic        bad_char;
  logic        last;

  modport source (output valid, row_x, row_y, row_bits, color, bad_char, last,
                  input ready);
  modport sink   (input valid, row_x, row_y, row_bits, color, bad_char, last,
                  output ready);
endinterface

interface bgre_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/bgre_font_mem.sv
module bgre_font_mem #(
  parameter int DEPTH = bgre_pkg::FONT_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  // Single-port byte store; read data is registered.
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/bitmap_glyph_row_expander.sv
// A draw is taken in idle, passes an offset multiply and a range check, then gives a
// single flagged result or, per row, reads its B font bytes (ceil(width/8), 0 to 4), one
// font read per byte, and gives the row (a blank row, without reads, when B is zero).
// Each result waits for a free output slot, so a low out ready stalls the draw. Commands
// wait until a draw has finished; loads are taken back to back. Reset (rst_n low at a
// clock edge) restores the register defaults; font memory is undefined.
module bitmap_glyph_row_expander #(
  parameter int FONT_BYTES = bgre_pkg::FONT_BYTES_DEF,
  parameter int MAX_WIDTH  = bgre_pkg::MAX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  bgre_in_if.sink    in_ch,
  bgre_out_if.source out_ch,
  bgre_cfg_if.sink   cfg_ch
);

  localparam int          AW         = $clog2(FONT_BYTES);
  localparam logic [16:0] FONT_LIMIT = 17'(FONT_BYTES);
  localparam logic [5:0]  WIDTH_CAP  = 6'(MAX_WIDTH);
  localparam logic [5:0]  ROW_CAP    = 6'(bgre_pkg::MAX_ROWS);

  // The sequencer walks a draw through an offset multiply, a range check, then a flagged
  // result or, per row: wait for the output slot, issue B reads, merge the last byte.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_BAD,
    ST_ROW_WAIT,
    ST_ROW_RD,
    ST_ROW_END
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [5:0]  glyph_width_r;
  logic [5:0]  glyph_height_r;
  logic [13:0] font_base_r;
  logic [15:0] ink_color_r;

  // Draw context.
  logic [7:0]    code_r;
  logic [15:0]   x_r;
  logic [15:0]   y_r;
  logic [7:0]    gbytes_r;
  logic [15:0]   off_r;
  logic [AW-1:0] addr_r;
  logic [5:0]    row_r;
  logic [1:0]    k_r;
  logic          rd_vld_r;
  logic [1:0]    rd_k_r;
  logic [3:0][7:0] acc_r;
  logic [3:0][7:0] acc_nxt;

  // Output register.
  logic        out_valid_r;
  logic [15:0] out_x_r;
  logic [15:0] out_y_r;
  logic [31:0] out_bits_r;
  logic [15:0] out_color_r;
  logic        out_bad_r;
  logic        out_last_r;

  // Geometry of registers the user must let stay put while a draw runs; not enforced.
  logic [5:0]  w_cl;
  logic [5:0]  h_cl;
  logic [6:0]  w_round;
  logic [2:0]  bpr;
  logic [8:0]  gbytes_full;
  logic [31:0] col_mask;
  logic [16:0] start_addr;
  logic [16:0] end_addr;
  logic        draw_bad;
  logic        last_row;
  logic        rd_last;

  // Handshake and memory port.
  logic          in_fire;
  logic          cfg_fire;
  logic          out_take;
  logic          slot_free;
  logic          out_load;
  logic [16:0]   load_ext;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cfg_fire  = cfg_ch.valid && cfg_ch.ready;
  assign out_take  = out_valid_r && out_ch.ready;
  // The output slot is free if empty or being emptied at this edge.
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign w_cl        = (glyph_width_r > WIDTH_CAP) ? WIDTH_CAP : glyph_width_r;
  assign h_cl        = (glyph_height_r > ROW_CAP) ? ROW_CAP : glyph_height_r;
  assign w_round     = {1'b0, w_cl} + 7'd7;
  assign bpr         = w_round[5:3];
  assign gbytes_full = {3'b000, h_cl} * {6'd0, bpr};
  // A shift by the full word width leaves no columns, which covers width zero.
  assign col_mask    = 32'hFFFF_FFFF << (6'd32 - w_cl);

  assign start_addr = {3'b000, font_base_r} + {1'b0, off_r};
  assign end_addr   = start_addr + {9'd0, gbytes_r};
  assign draw_bad   = (code_r < bgre_pkg::FIRST_CODE) || (end_addr > FONT_LIMIT);

  assign last_row = ((row_r + 6'd1) == h_cl);
  assign rd_last  = (({1'b0, k_r} + 3'd1) == bpr);

  // Out-of-range loads are dropped.
  assign load_ext = {3'b000, in_ch.load_address};
  assign mem_we   = in_fire && (in_ch.command == bgre_pkg::CMD_LOAD)
                    && (load_ext < FONT_LIMIT);
  assign mem_addr = (state_r == ST_IDLE) ? load_ext[AW-1:0] : addr_r;

  bgre_font_mem #(
    .DEPTH (FONT_BYTES),
    .AW    (AW)
  ) u_font_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_ch.load_byte),
    .rdata (mem_rdata)
  );

  // Returning byte lands in its lane, leftmost byte at the top.
  always_comb begin
    acc_nxt = acc_r;
    if (rd_vld_r) begin
      acc_nxt[2'd3 - rd_k_r] = mem_rdata;
    end
  end

  always_comb begin
    out_load = 1'b0;
    unique case (state_r)
      ST_BAD:      out_load = slot_free;
      ST_ROW_WAIT: out_load = slot_free && (bpr == 3'd0);
      ST_ROW_END:  out_load = 1'b1;
      default:     out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      rd_vld_r       <= 1'b0;
      glyph_width_r  <= bgre_pkg::RST_WIDTH;
      glyph_height_r <= bgre_pkg::RST_HEIGHT;
      font_base_r    <= bgre_pkg::RST_BASE;
      ink_color_r    <= bgre_pkg::RST_INK;
    end else begin
      if (cfg_fire) begin
        unique case (bgre_pkg::cfg_reg_t'(cfg_ch.index))
          bgre_pkg::REG_WIDTH:  glyph_width_r  <= cfg_ch.data[5:0];
          bgre_pkg::REG_HEIGHT: glyph_height_r <= cfg_ch.data[5:0];
          bgre_pkg::REG_BASE:   font_base_r    <= cfg_ch.data[13:0];
          bgre_pkg::REG_INK:    ink_color_r    <= cfg_ch.data;
        endcase
      end

      // A load into the slot wins over the drain of the previous result.
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_x_r     <= x_r;
        out_y_r     <= y_r;
        out_color_r <= ink_color_r;
      end

      rd_vld_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire && (in_ch.command == bgre_pkg::CMD_DRAW)) begin
            code_r   <= in_ch.char_code;
            x_r      <= in_ch.origin_x;
            y_r      <= in_ch.origin_y;
            gbytes_r <= gbytes_full[7:0];
            state_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          off_r   <= {8'd0, code_r - bgre_pkg::FIRST_CODE} * {8'd0, gbytes_r};
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          addr_r <= start_addr[AW-1:0];
          row_r  <= 6'd0;
          if (draw_bad) begin
            state_r <= ST_BAD;
          end else if (h_cl == 6'd0) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_ROW_WAIT;
          end
        end
        ST_BAD: begin
          if (slot_free) begin
            out_bits_r <= '0;
            out_bad_r  <= 1'b1;
            out_last_r <= 1'b1;
            state_r    <= ST_IDLE;
          end
        end
        ST_ROW_WAIT: begin
          acc_r <= '0;
          k_r   <= 2'd0;
          if (slot_free) begin
            if (bpr == 3'd0) begin
              // No bytes to fetch: the row is blank.
              out_bits_r <= '0;
              out_bad_r  <= 1'b0;
              out_last_r <= last_row;
              y_r        <= y_r + 16'd1;
              row_r      <= row_r + 6'd1;
              state_r    <= last_row ? ST_IDLE : ST_ROW_WAIT;
            end else begin
              state_r <= ST_ROW_RD;
            end
          end
        end
        ST_ROW_RD: begin
          acc_r    <= acc_nxt;
          rd_vld_r <= 1'b1;
          rd_k_r   <= k_r;
          addr_r   <= addr_r + 1'b1;
          k_r      <= k_r + 2'd1;
          if (rd_last) begin
            state_r <= ST_ROW_END;
          end
        end
        ST_ROW_END: begin
          out_bits_r <= acc_nxt & col_mask;
          out_bad_r  <= 1'b0;
          out_last_r <= last_row;
          y_r        <= y_r + 16'd1;
          row_r      <= row_r + 6'd1;
          state_r    <= last_row ? ST_IDLE : ST_ROW_WAIT;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.row_x    = out_x_r;
  assign out_ch.row_y    = out_y_r;
  assign out_ch.row_bits = out_bits_r;
  assign out_ch.color    = out_color_r;
  assign out_ch.bad_char = out_bad_r;
  assign out_ch.last     = out_last_r;

  // Font writes only happen between draws, so reads never meet a write.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("font write outside idle");

  // The final byte of a row must be in flight when the row is closed.
  a_end_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROW_END) |-> rd_vld_r)
    else $error("row closed without its last byte");

  // A new result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("output register overwritten");

  // A flagged result is always the only result of its character.
  a_bad_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_char) |-> out_ch.last)
    else $error("flagged result not marked last");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for bitmap_glyph_row_expander.
//
// Inputs and the register write channel change on the falling clock edge.
// Everything is sampled on the rising edge, where a transfer takes place
// when valid and ready are both high. The input driver is fed from a queue
// of pending commands that the stimulus process fills one phase at a time.
// Between phases the block is drained and the glyph geometry registers are
// rewritten.
//
// Every accepted command is run through a local model of the character
// generator. That model keeps its own copy of the font memory and of the
// registers. It appends the predicted row results to a queue, and each
// result transfer on the output is checked field by field against the
// oldest entry of that queue.
//
// The stimulus never draws a glyph whose font bytes have not all been
// loaded, because the font memory holds no defined value until written.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FONT_SIZE = bgre_pkg::FONT_BYTES_DEF;
  localparam int WIDTH_CAP = bgre_pkg::MAX_WIDTH_DEF;

  // DRAIN_CYCLES is the quiet time before any register is rewritten.
  localparam int DRAIN_CYCLES      = 256;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int RESULT_WAIT_LIMIT = 100000;
  localparam int RANDOM_PHASES     = 8;
  localparam int PHASE_QUOTA       = 35;
  localparam int STALL_PHASE       = 2;
  localparam int TIMEOUT_NS        = 10_000_000;

  typedef struct packed {
    logic        command;
    logic [13:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  char_code;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } glyph_cmd_t;

  typedef struct packed {
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [31:0] row_bits;
    logic [15:0] color;
    logic        bad_char;
    logic        last;
  } glyph_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  bgre_in_if  glyph_in ();
  bgre_out_if row_out ();
  bgre_cfg_if reg_wr ();

  bitmap_glyph_row_expander i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (glyph_in),
    .out_ch(row_out),
    .cfg_ch(reg_wr)
  );

  // Commands waiting for the input driver, and the rows still owed by the block.
  glyph_cmd_t cmds_pending[$];
  glyph_row_t rows_due[$];

  int mismatches = 0;

  // These are the local model's copy of the registers and of the font memory.
  // The monitor alone updates them.
  logic [5:0]  pred_width;
  logic [5:0]  pred_height;
  logic [13:0] pred_base;
  logic [15:0] pred_ink;
  bit   [7:0]  font_copy [FONT_SIZE];

  // This is the stimulus process's view of the geometry (clamped) and of the
  // bytes it has loaded so far. It is used only to pick legal draws.
  int gen_w;
  int gen_h;
  int gen_base;
  bit gen_written [FONT_SIZE];
  int cmds_queued = 0;

  // These hold the handshake state of the driver processes and the flags that steer them.
  logic in_accepted = 1'b0;
  int   in_gap      = 0;
  int   out_gap     = 0;
  bit   idle_bursts = 1'b1;
  bit   stall_armed = 1'b0;
  bit   rx_hold     = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("ERROR at %0t ns: %s: expected %h, got %h", $time, what, want, got);
    mismatches++;
  endtask

  // This is the character generator model. A load updates the font copy.
  // A draw appends either one flagged row or one row for each glyph row.
  task automatic expand_glyph(input glyph_cmd_t c);
    int          w;
    int          h;
    int          bpr;
    int          n;
    int          first;
    logic [31:0] mask;
    logic [31:0] bits;
    glyph_row_t  r;
    if (c.command == bgre_pkg::CMD_LOAD) begin
      if (int'(c.load_address) < FONT_SIZE) font_copy[c.load_address] = c.load_byte;
      return;
    end
    w   = (int'(pred_width) > WIDTH_CAP) ? WIDTH_CAP : int'(pred_width);
    h   = (int'(pred_height) > bgre_pkg::MAX_ROWS) ? bgre_pkg::MAX_ROWS : int'(pred_height);
    bpr = (w + 7) / 8;
    n   = h * bpr;
    first = 0;
    if (c.char_code >= bgre_pkg::FIRST_CODE)
      first = int'(pred_base) + (int'(c.char_code) - int'(bgre_pkg::FIRST_CODE)) * n;
    r.row_x = c.origin_x;
    r.row_y = c.origin_y;
    r.color = pred_ink;
    // A code below the printable range, or a glyph that runs off the end
    // of the font memory, gives a single flagged row.
    if (c.char_code < bgre_pkg::FIRST_CODE || first + n > FONT_SIZE) begin
      r.row_bits = '0;
      r.bad_char = 1'b1;
      r.last     = 1'b1;
      rows_due.push_back(r);
      return;
    end
    mask = (w == 0) ? '0 : (32'hFFFF_FFFF << (32 - w));
    for (int row = 0; row < h; row++) begin
      bits = '0;
      for (int k = 0; k < bpr; k++)
        bits |= {24'h0, font_copy[first + row * bpr + k]} << (24 - 8 * k);
      r.row_bits = bits & mask;
      r.bad_char = 1'b0;
      r.last     = (row == h - 1);
      rows_due.push_back(r);
      r.row_y = r.row_y + 16'd1;
    end
  endtask

  task automatic check_row();
    glyph_row_t got;
    glyph_row_t want;
    got = glyph_row_t'{row_out.row_x, row_out.row_y, row_out.row_bits, row_out.color,
                       row_out.bad_char, row_out.last};
    if (rows_due.size() == 0) begin
      report_mismatch("row with nothing outstanding, row_bits", '0, got.row_bits);
      return;
    end
    want = rows_due.pop_front();
    if (got.row_x !== want.row_x)
      report_mismatch("row_x", 32'(want.row_x), 32'(got.row_x));
    if (got.row_y !== want.row_y)
      report_mismatch("row_y", 32'(want.row_y), 32'(got.row_y));
    if (got.row_bits !== want.row_bits)
      report_mismatch("row_bits", want.row_bits, got.row_bits);
    if (got.color !== want.color)
      report_mismatch("color", 32'(want.color), 32'(got.color));
    if (got.bad_char !== want.bad_char)
      report_mismatch("bad_char", 32'(want.bad_char), 32'(got.bad_char));
    if (got.last !== want.last)
      report_mismatch("last", 32'(want.last), 32'(got.last));
  endtask

  // Monitor: all transfers are observed here, on the rising edge. A result
  // is checked before a new command is modeled, although the two can never
  // be related within the same cycle.
  always @(posedge clk) begin : watch_transfers
    in_accepted <= rst_n && glyph_in.valid && glyph_in.ready;
    if (!rst_n) begin
      pred_width  = bgre_pkg::RST_WIDTH;
      pred_height = bgre_pkg::RST_HEIGHT;
      pred_base   = bgre_pkg::RST_BASE;
      pred_ink    = bgre_pkg::RST_INK;
    end else begin
      if (reg_wr.valid && reg_wr.ready) begin
        case (reg_wr.index)
          bgre_pkg::REG_WIDTH:  pred_width  = reg_wr.data[5:0];
          bgre_pkg::REG_HEIGHT: pred_height = reg_wr.data[5:0];
          bgre_pkg::REG_BASE:   pred_base   = reg_wr.data[13:0];
          bgre_pkg::REG_INK:    pred_ink    = reg_wr.data;
          default: ;
        endcase
      end
      if (row_out.valid && row_out.ready) check_row();
      if (glyph_in.valid && glyph_in.ready)
        expand_glyph(glyph_cmd_t'{glyph_in.command, glyph_in.load_address,
                                  glyph_in.load_byte, glyph_in.char_code,
                                  glyph_in.origin_x, glyph_in.origin_y});
    end
  end

  // Input driver: once a command is offered it is held until its transfer.
  // Between commands the driver sometimes inserts an idle burst. It does
  // not do so while the receiver is held off, so that the block fills up.
  always @(negedge clk) begin : feed_cmds
    bit holding;
    holding = glyph_in.valid && !in_accepted;
    if (glyph_in.valid && in_accepted) cmds_pending.delete(0);
    if (!rst_n) begin
      glyph_in.valid <= 1'b0;
    end else if (!holding) begin
      if (in_gap == 0 && idle_bursts && !rx_hold && cmds_pending.size() != 0 &&
          $urandom_range(0, 9) == 0)
        in_gap = $urandom_range(1, 19);
      if (in_gap != 0) begin
        in_gap--;
        glyph_in.valid <= 1'b0;
      end else if (cmds_pending.size() != 0) begin
        glyph_in.valid        <= 1'b1;
        glyph_in.command      <= cmds_pending[0].command;
        glyph_in.load_address <= cmds_pending[0].load_address;
        glyph_in.load_byte    <= cmds_pending[0].load_byte;
        glyph_in.char_code    <= cmds_pending[0].char_code;
        glyph_in.origin_x     <= cmds_pending[0].origin_x;
        glyph_in.origin_y     <= cmds_pending[0].origin_y;
      end else begin
        glyph_in.valid <= 1'b0;
      end
    end
  end

  // Output driver: ready drops in random bursts. It stays low for the whole
  // long hold-off.
  always @(negedge clk) begin : take_rows
    if (!rst_n) begin
      row_out.ready <= 1'b0;
    end else begin
      if (out_gap == 0 && idle_bursts && !rx_hold && $urandom_range(0, 7) == 0)
        out_gap = $urandom_range(1, 19);
      if (rx_hold) begin
        row_out.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        row_out.ready <= 1'b0;
      end else begin
        row_out.ready <= 1'b1;
      end
    end
  end

  // This is the long receiver hold-off. The sender keeps offering commands,
  // so the block backs up and must stall its input.
  initial begin : long_stall
    wait (stall_armed);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (LONG_STALL_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL bitmap_glyph_row_expander");
    $finish;
  end

  task automatic write_reg(input bgre_pkg::cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    reg_wr.valid <= 1'b1;
    reg_wr.index <= idx;
    reg_wr.data  <= value;
    do @(posedge clk); while (!reg_wr.ready);
    @(negedge clk);
    reg_wr.valid <= 1'b0;
  endtask

  // This writes all four registers. The unused upper bits of the narrow
  // ones get random values, which the block must ignore. It returns on a
  // rising edge, so new commands are queued away from the driver's edge.
  task automatic set_geometry(input int width, input int height, input int base,
                              input logic [15:0] ink);
    logic [15:0] word;
    word = 16'($urandom);
    word[5:0] = 6'(width);
    write_reg(bgre_pkg::REG_WIDTH, word);
    word = 16'($urandom);
    word[5:0] = 6'(height);
    write_reg(bgre_pkg::REG_HEIGHT, word);
    word = 16'($urandom);
    word[13:0] = 14'(base);
    write_reg(bgre_pkg::REG_BASE, word);
    write_reg(bgre_pkg::REG_INK, ink);
    gen_w    = (width > WIDTH_CAP) ? WIDTH_CAP : width;
    gen_h    = (height > bgre_pkg::MAX_ROWS) ? bgre_pkg::MAX_ROWS : height;
    gen_base = base;
    @(posedge clk);
  endtask

  // This waits until every queued command has been taken and every
  // predicted row has arrived, and then lets the block go quiet. Rows that
  // never come are reported once and then dropped.
  task automatic settle();
    int waited;
    waited = 0;
    @(posedge clk);
    while (cmds_pending.size() != 0) @(posedge clk);
    @(negedge clk);
    while (rows_due.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (rows_due.size() != 0) begin
      report_mismatch("rows never delivered, count", rows_due.size(), '0);
      rows_due.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // This returns a command with every field random. Each queue_* task then
  // sets the fields that matter for its kind of command.
  function automatic glyph_cmd_t scrambled_cmd();
    glyph_cmd_t c;
    c.command      = 1'($urandom);
    c.load_address = 14'($urandom);
    c.load_byte    = 8'($urandom);
    c.char_code    = 8'($urandom);
    c.origin_x     = 16'($urandom);
    c.origin_y     = 16'($urandom);
    return c;
  endfunction

  task automatic queue_load(input int addr, input logic [7:0] value);
    glyph_cmd_t c;
    c = scrambled_cmd();
    c.command      = bgre_pkg::CMD_LOAD;
    c.load_address = 14'(addr);
    c.load_byte    = value;
    cmds_pending.push_back(c);
    gen_written[addr] = 1'b1;
    cmds_queued++;
  endtask

  task automatic queue_draw(input int code, input logic [15:0] x, input logic [15:0] y);
    glyph_cmd_t c;
    c = scrambled_cmd();
    c.command   = bgre_pkg::CMD_DRAW;
    c.char_code = 8'(code);
    c.origin_x  = x;
    c.origin_y  = y;
    cmds_pending.push_back(c);
    cmds_queued++;
  endtask

  function automatic logic [7:0] pick_font_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_origin();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF - 16'($urandom_range(0, 40));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int glyph_bytes();
    return gen_h * ((gen_w + 7) / 8);
  endfunction

  function automatic int glyph_start(input int code);
    return gen_base + (code - int'(bgre_pkg::FIRST_CODE)) * glyph_bytes();
  endfunction

  // This is true when a draw of this code would fetch a font byte that was
  // never loaded. Flagged draws and draws that fetch nothing are always safe.
  function automatic bit draw_reads_unwritten(input int code);
    int s;
    int n;
    n = glyph_bytes();
    if (code < int'(bgre_pkg::FIRST_CODE) || n == 0) return 1'b0;
    s = glyph_start(code);
    if (s + n > FONT_SIZE) return 1'b0;
    for (int a = s; a < s + n; a++)
      if (!gen_written[a]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_glyph_fill(input int code);
    int s;
    s = glyph_start(code);
    for (int a = s; a < s + glyph_bytes(); a++) queue_load(a, pick_font_byte());
  endtask

  // Most of each phase loads a glyph and then draws it a few times. The
  // remainder is noise: draws of random codes (many flagged) and loads to
  // random addresses.
  task automatic random_phase(input int quota);
    int first_count;
    int code;
    int pick;
    first_count = cmds_queued;
    while (cmds_queued - first_count < quota) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        code = int'(bgre_pkg::FIRST_CODE) + $urandom_range(0, 11);
        if (draw_reads_unwritten(code) || $urandom_range(0, 3) == 0) begin
          if (glyph_start(code) + glyph_bytes() <= FONT_SIZE) queue_glyph_fill(code);
        end
        repeat ($urandom_range(1, 3)) queue_draw(code, pick_origin(), pick_origin());
      end else if (pick < 8) begin
        code = $urandom_range(0, 255);
        if (draw_reads_unwritten(code))
          queue_load($urandom_range(0, FONT_SIZE - 1), 8'($urandom));
        else
          queue_draw(code, pick_origin(), pick_origin());
      end else begin
        queue_load($urandom_range(0, FONT_SIZE - 1), 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int width;
    int height;
    int base;
    int eff_w;
    int eff_h;
    glyph_in.valid        = 1'b0;
    glyph_in.command      = bgre_pkg::CMD_LOAD;
    glyph_in.load_address = '0;
    glyph_in.load_byte    = '0;
    glyph_in.char_code    = '0;
    glyph_in.origin_x     = '0;
    glyph_in.origin_y     = '0;
    row_out.ready         = 1'b0;
    reg_wr.valid          = 1'b0;
    reg_wr.index          = bgre_pkg::REG_WIDTH;
    reg_wr.data           = '0;
    gen_w    = int'(bgre_pkg::RST_WIDTH);
    gen_h    = int'(bgre_pkg::RST_HEIGHT);
    gen_base = int'(bgre_pkg::RST_BASE);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset geometry, load the first and last font addresses and
    // draw the two ends of the unprintable code range.
    queue_load(0, 8'h00);
    queue_load(FONT_SIZE - 1, 8'hFF);
    queue_draw(0, 16'h0000, 16'h0000);
    queue_draw(31, 16'hFFFF, 16'hFFFF);
    settle();

    // An 8x2 glyph at address zero, drawn once at the screen origin and once
    // at the far corner. The second row wraps to screen row zero there.
    set_geometry(8, 2, 0, 16'h0000);
    queue_load(0, 8'hFF);
    queue_load(1, 8'h81);
    queue_draw(32, 16'h0000, 16'h0000);
    queue_draw(32, 16'hFFFF, 16'hFFFF);
    settle();

    // A one-pixel glyph in the very last font byte. The next code would end
    // past the memory, and so would the highest code.
    set_geometry(1, 1, FONT_SIZE - 1, 16'hFFFF);
    queue_load(FONT_SIZE - 1, 8'hC0);
    queue_draw(32, 16'd100, 16'd200);
    queue_draw(33, pick_origin(), pick_origin());
    queue_draw(255, pick_origin(), pick_origin());
    settle();

    // A width above the limit is clipped to 32 columns, so four bytes are
    // fetched per row.
    set_geometry(63, 1, 100, 16'hA5A5);
    for (int a = 100; a < 104; a++) queue_load(a, pick_font_byte());
    queue_draw(32, pick_origin(), pick_origin());
    settle();

    // A zero width fetches nothing. A height above the limit is clipped to
    // 32 rows, which is the most rows a single draw can give.
    set_geometry(0, 63, $urandom_range(0, FONT_SIZE - 1), 16'($urandom));
    queue_draw(200, pick_origin(), pick_origin());
    queue_draw(32, pick_origin(), pick_origin());
    settle();

    // A zero height gives no rows at all, yet a bad code is still flagged.
    set_geometry(9, 0, 0, 16'($urandom));
    queue_draw(50, pick_origin(), pick_origin());
    queue_draw(10, pick_origin(), pick_origin());
    settle();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       width = 0;
        1:       width = $urandom_range(33, 63);
        2:       width = 32;
        default: width = $urandom_range(1, 31);
      endcase
      case ($urandom_range(0, 7))
        0:       height = 0;
        1:       height = $urandom_range(33, 63);
        2:       height = $urandom_range(9, 32);
        default: height = $urandom_range(1, 8);
      endcase
      // Keep glyphs small enough that loading one does not swamp the phase.
      eff_w = (width > WIDTH_CAP) ? WIDTH_CAP : width;
      eff_h = (height > bgre_pkg::MAX_ROWS) ? bgre_pkg::MAX_ROWS : height;
      if (((eff_w + 7) / 8) * eff_h > 48) width = $urandom_range(1, 8);
      if (ph == STALL_PHASE) begin
        width  = 8;
        height = 20;
      end
      base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FONT_SIZE - 1)
                                         : $urandom_range(0, 1023);
      // The closing phases run with no idle cycles on either side.
      idle_bursts = (ph < RANDOM_PHASES - 2) ? ($urandom_range(0, 4) != 0) : 1'b0;
      set_geometry(width, height, base, 16'($urandom));
      if (ph == STALL_PHASE) stall_armed = 1'b1;
      random_phase(PHASE_QUOTA);
      settle();
    end

    if (mismatches == 0) begin
      $display("PASS bitmap_glyph_row_expander");
    end else begin
      $display("FAIL bitmap_glyph_row_expander");
    end
    $finish;
  end

endmodule
